// File: rtl/core/pcmpdm_pkg.sv
// ----------------------------------------------------------------------------
// pcmpdm_pkg
// Shared types, constants and helper functions of the PCM to PDM/PWM byte
// encoder.
// ----------------------------------------------------------------------------
package pcmpdm_pkg;

   localparam int unsigned SAMPLE_W           = 16;
   localparam int unsigned BYTE_W             = 8;
   localparam int unsigned BYTE_IDX_W         = 3;
   localparam int unsigned PWM_COUNT_W        = 6;
   localparam int unsigned PDM_BYTES_DEFAULT  = 8;
   localparam int unsigned BITS_PER_BYTE      = 8;

   // Last byte indices of the two PWM word sizes.
   localparam logic [BYTE_IDX_W-1:0] PWM32_LAST_IDX = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] PWM64_LAST_IDX = 3'd7;

   // Values of the output_mode register.
   typedef enum logic [1:0] {
      FMT_PDM   = 2'd0,
      FMT_PWM32 = 2'd1,
      FMT_PWM64 = 2'd2
   } mode_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      mode_type              mode;
      logic [SAMPLE_W-1:0]   level;   // sample in offset binary
   } work_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   // One byte of a thermometer word whose low 'count' bits are set.
   function automatic logic [BYTE_W-1:0] pwm_byte(
      input logic [PWM_COUNT_W-1:0] count,
      input logic [BYTE_IDX_W-1:0]  idx
   );
      logic [PWM_COUNT_W:0] base;
      logic [PWM_COUNT_W:0] rest;
      logic [BYTE_W:0]      mask;
      base = {1'b0, idx, 3'b000};
      rest = {1'b0, count} - base;
      mask = '0;
      if ({1'b0, count} <= base) begin
         mask = '0;
      end else if (rest >= (PWM_COUNT_W+1)'(BITS_PER_BYTE)) begin
         mask = {1'b0, {BYTE_W{1'b1}}};
      end else begin
         mask = (9'd1 << rest[3:0]) - 9'd1;
      end
      return mask[BYTE_W-1:0];
   endfunction

endpackage

// File: rtl/core/pcmpdm_front.sv
// ----------------------------------------------------------------------------
// pcmpdm_front
// Holds the mode register, accepts samples and classifies them for the back.
// ----------------------------------------------------------------------------
module pcmpdm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic signed [pcmpdm_pkg::SAMPLE_W-1:0] req_audio_sample,
   output logic                                  req_stall,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_write_data,
   input  pcmpdm_pkg::q_status_type              q_status,
   output logic                                  push,
   output pcmpdm_pkg::work_type                  push_item
);

   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic       accept;
   logic       known_mode;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write_enable) begin
         mode_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcmpdm_pkg::FMT_PDM;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // The unused mode code takes the item and produces nothing.
   // Flipping the sign bit gives offset binary.
   always_comb begin
      known_mode      = 1'b1;
      push_item.mode  = pcmpdm_pkg::FMT_PDM;
      push_item.level = {~req_audio_sample[pcmpdm_pkg::SAMPLE_W-1],
                         req_audio_sample[pcmpdm_pkg::SAMPLE_W-2:0]};
      unique case (mode_ff)
         pcmpdm_pkg::FMT_PDM:   push_item.mode = pcmpdm_pkg::FMT_PDM;
         pcmpdm_pkg::FMT_PWM32: push_item.mode = pcmpdm_pkg::FMT_PWM32;
         pcmpdm_pkg::FMT_PWM64: push_item.mode = pcmpdm_pkg::FMT_PWM64;
         default:               known_mode     = 1'b0;
      endcase
   end

   assign push = accept && known_mode;

endmodule

// File: rtl/core/pcmpdm_queue.sv
// ----------------------------------------------------------------------------
// pcmpdm_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pcmpdm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcmpdm_pkg::work_type     push_item,
   input  logic                     pop,
   output pcmpdm_pkg::work_type     head_item,
   output pcmpdm_pkg::q_status_type q_status
);

   pcmpdm_pkg::work_type entry_ff [2];
   logic                 wr_ptr_ff;
   logic                 wr_ptr_in;
   logic                 rd_ptr_ff;
   logic                 rd_ptr_in;
   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   logic                 do_push;
   logic                 do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entry_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == 2'd2);
   assign q_status.not_empty = (count_ff != 2'd0);

endmodule

// File: rtl/core/pcmpdm_back.sv
// ----------------------------------------------------------------------------
// pcmpdm_back
// Expands one classified item into its bytes, one per cycle unless stalled,
// into a registered output stage. Owns the delta-sigma accumulator.
// ----------------------------------------------------------------------------
module pcmpdm_back #(
   parameter int unsigned PDM_BYTES_PER_SAMPLE = pcmpdm_pkg::PDM_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pcmpdm_pkg::q_status_type         q_status,
   input  pcmpdm_pkg::work_type             head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pcmpdm_pkg::BYTE_W-1:0]    rsp_line_byte,
   output logic                             rsp_last_of_sample
);

   localparam logic [pcmpdm_pkg::BYTE_IDX_W-1:0] PDM_LAST_IDX =
      pcmpdm_pkg::BYTE_IDX_W'(PDM_BYTES_PER_SAMPLE - 1);

   localparam int unsigned SW = pcmpdm_pkg::SAMPLE_W;

   pcmpdm_pkg::work_type                  cur_ff;
   logic                                  busy_ff;
   logic                                  busy_in;
   logic [pcmpdm_pkg::BYTE_IDX_W-1:0]     idx_ff;
   logic [pcmpdm_pkg::BYTE_IDX_W-1:0]     idx_in;
   logic [SW-1:0]                         acc_ff;
   logic [SW-1:0]                         acc_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [pcmpdm_pkg::BYTE_W-1:0]         rsp_byte_ff;
   logic                                  rsp_last_ff;

   logic                                  advance;
   logic                                  emit;
   logic                                  is_last;
   logic [pcmpdm_pkg::BYTE_IDX_W-1:0]     last_idx;
   logic [pcmpdm_pkg::BYTE_W-1:0]         pdm_byte;
   logic [SW-1:0]                         pdm_acc;
   logic [pcmpdm_pkg::BYTE_W-1:0]         out_byte;
   logic [pcmpdm_pkg::PWM_COUNT_W-1:0]    pwm_count;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = busy_ff && advance;

   always_comb begin
      last_idx  = PDM_LAST_IDX;
      pwm_count = '0;
      unique case (cur_ff.mode)
         pcmpdm_pkg::FMT_PDM: begin
            last_idx = PDM_LAST_IDX;
         end
         pcmpdm_pkg::FMT_PWM32: begin
            last_idx  = pcmpdm_pkg::PWM32_LAST_IDX;
            pwm_count = {1'b0, cur_ff.level[SW-1:SW-5]};
         end
         pcmpdm_pkg::FMT_PWM64: begin
            last_idx  = pcmpdm_pkg::PWM64_LAST_IDX;
            pwm_count = cur_ff.level[SW-1:SW-6];
         end
         default: begin
            last_idx = PDM_LAST_IDX;
         end
      endcase
   end

   assign is_last = (idx_ff == last_idx);

   // Eight first-order delta-sigma steps. The running sum after j adds is
   // acc + j * level, and the carry of add j is the change of bit SW between
   // the sums after j-1 and j adds, so all eight sums are formed side by
   // side. The first bit lands in bit 0.
   always_comb begin
      logic [SW+3:0] prev_sum;
      logic [SW+3:0] next_sum;
      prev_sum = {4'b0000, acc_ff};
      next_sum = prev_sum;
      pdm_byte = '0;
      for (int j = 1; j <= pcmpdm_pkg::BITS_PER_BYTE; j++) begin
         next_sum      = {4'b0000, acc_ff} + (SW+4)'(j) * {4'b0000, cur_ff.level};
         pdm_byte[j-1] = next_sum[SW] ^ prev_sum[SW];
         prev_sum      = next_sum;
      end
      pdm_acc = prev_sum[SW-1:0];
   end

   always_comb begin
      if (cur_ff.mode == pcmpdm_pkg::FMT_PDM) begin
         out_byte = pdm_byte;
      end else begin
         out_byte = pcmpdm_pkg::pwm_byte(pwm_count, idx_ff);
      end
   end

   // A new item is loaded while the last byte of the current one leaves.
   assign pop = q_status.not_empty && (!busy_ff || (emit && is_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (emit) begin
         idx_in = idx_ff + 1'b1;
         if (cur_ff.mode == pcmpdm_pkg::FMT_PDM) begin
            acc_in = pdm_acc;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_item;
      end
      if (emit) begin
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_byte      = rsp_byte_ff;
   assign rsp_last_of_sample = rsp_last_ff;

endmodule

// File: rtl/core/pcm_to_pdm_pwm_byte_encoder_core.sv
// ----------------------------------------------------------------------------
// pcm_to_pdm_pwm_byte_encoder_core
// Turns signed 16-bit PCM samples into UART bytes, as first-order PDM or as
// 32-bit or 64-bit thermometer PWM words.
// ----------------------------------------------------------------------------
// The req_ channel carries one signed PCM sample per item; the rsp_ channel
// carries one line byte per item, bit 0 to be sent first, with
// rsp_last_of_sample set on the final byte of each sample. Both channels
// move an item at a clock edge where valid is high and stall is low.
// The csr_ port writes the two-bit output mode (0 PDM, 1 PWM32, 2 PWM64);
// change it only while no sample is in flight. Mode 3 swallows samples.
// An accepted sample passes through a queue entry and the back's item
// register before its first byte reaches the output register. After that
// one byte leaves per cycle while rsp_stall is low. A sample yields
// PDM_BYTES_PER_SAMPLE bytes in PDM mode, 4 in PWM32 and 8 in PWM64. The
// two-entry queue between front and back keeps taking samples while the
// back is busy, so the input only stalls once two samples wait behind the
// one being expanded. When the receiver stalls, the output register holds
// its byte and the back part freezes; the queue then fills and req_stall
// rises. Reset (synchronous) empties the queue, drops the output byte,
// clears the delta-sigma accumulator and sets PDM mode.
// ----------------------------------------------------------------------------
module pcm_to_pdm_pwm_byte_encoder_core #(
   parameter int unsigned PDM_BYTES_PER_SAMPLE = pcmpdm_pkg::PDM_BYTES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Sample input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pcmpdm_pkg::SAMPLE_W-1:0] req_audio_sample,
   // Byte output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pcmpdm_pkg::BYTE_W-1:0]          rsp_line_byte,
   output logic                                   rsp_last_of_sample,
   // Mode register
   input  logic                                   csr_write_enable,
   input  logic [1:0]                             csr_write_data
);

   pcmpdm_pkg::q_status_type q_status;
   pcmpdm_pkg::work_type     push_item;
   pcmpdm_pkg::work_type     head_item;
   logic                     push;
   logic                     pop;

   // Front: mode register, input handshake, offset-binary conversion.
   pcmpdm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_audio_sample (req_audio_sample),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   // Queue that decouples acceptance from byte generation.
   pcmpdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // Back: one byte per cycle, unless stalled, into the registered output stage.
   pcmpdm_back #(
      .PDM_BYTES_PER_SAMPLE (PDM_BYTES_PER_SAMPLE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_byte      (rsp_line_byte),
      .rsp_last_of_sample (rsp_last_of_sample)
   );

endmodule
